@@ hw/rtl/aesm4_pkg.sv @@
// Shared types, constants and the SM4 S-box for the affine-encoded SM4 core.
package aesm4_pkg;

  localparam int MapCount  = 168;
  localparam int MapWords  = 33;
  localparam int MapAw     = 8;
  localparam int RowAw     = 6;
  localparam int MapIn     = 0;
  localparam int MapOut    = 4;
  localparam int MapRound  = 8;
  localparam int MapC      = 104;
  localparam int MapD      = 136;
  localparam int DataBytes = 17;
  localparam int DataW     = DataBytes * 8;

  localparam logic OpLoad    = 1'b0;
  localparam logic OpEncrypt = 1'b1;

  // One map access: matrix rows plus vector, read as a single wide word.
  typedef struct packed {
    logic             valid;
    logic [MapAw-1:0] map;
  } map_rd_t;

  // SM4 S-box, one byte in, one byte out.
  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tab [256];
    tab = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};
    return tab[a];
  endfunction

endpackage

@@ hw/rtl/aesm4_map_mem.sv @@
// Map store: one wide word per map, 33 row-enable lanes, registered read.
module aesm4_map_mem (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [aesm4_pkg::MapAw-1:0]        wr_map,
  input  logic [aesm4_pkg::RowAw-1:0]        wr_row,
  input  logic [31:0]                        wr_data,
  input  aesm4_pkg::map_rd_t                 rd,
  output logic [aesm4_pkg::MapWords*32-1:0]  rd_data
);

  logic [aesm4_pkg::MapWords*32-1:0] mem [aesm4_pkg::MapCount];

  // Row-lane write: only the addressed 32-bit lane of the map word changes.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_map][wr_row*32 +: 32] <= wr_data;
    end
  end

  // Registered read of a whole map.
  always_ff @(posedge clk) begin
    if (rd.valid) begin
      rd_data <= mem[rd.map];
    end
  end

endmodule

@@ hw/rtl/aesm4_affine.sv @@
// Combinational affine map: matrix-vector product over GF(2) plus vector.
module aesm4_affine (
  input  logic [aesm4_pkg::MapWords*32-1:0] map_word,
  input  logic [31:0]                       x,
  output logic [31:0]                       y
);

  // Row r drives output bit 31-r; lane 32 is the added vector.
  always_comb begin
    for (int r = 0; r < 32; r++) begin
      y[31-r] = ^(map_word[r*32 +: 32] & x) ^ map_word[32*32 + 31 - r];
    end
  end

endmodule

@@ hw/rtl/affine_encoded_sm4_encrypt_core.sv @@
// Top level of the affine-encoded SM4 encryption core.
// A load request writes one row lane of the map store. An encrypt request takes
// 8 + 5*ROUNDS map reads, one per cycle from the map store, and then the result
// is registered. The single map-store read port sets this rate.
// One block is processed at a time; the result sits in an output register.
// rst clears the control state; the map store is undefined until loaded.
module affine_encoded_sm4_encrypt_core #(
  parameter int ROUNDS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata, low bit up: operation[0], map_index[8:1], row_index[14:9],
  // table_word[46:15], block_hi[110:47], block_lo[174:111], zero fill to 176
  input  logic [175:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata, low bit up: result_hi[63:0], result_lo[127:64]
  output logic [127:0] m_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DONE = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  localparam int RndW  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  state_t              state;
  logic                accept;
  logic                op;
  logic [7:0]          in_map;
  logic [5:0]          in_row;
  logic [31:0]         w [4];
  logic [31:0]         acc;
  logic [31:0]         sb;
  logic [2:0]          phase;      // issued-step phase within a round
  logic [RndW-1:0]     rnd;
  logic [1:0]          k;          // outer map index
  logic                in_outer;   // 1: input maps, 0: output maps or rounds
  logic                out_stage;
  logic                issuing;
  aesm4_pkg::map_rd_t  rd;
  logic [aesm4_pkg::MapWords*32-1:0] rd_data;
  logic [31:0]         ax;
  logic [31:0]         ay;
  // Step that the data from the memory belongs to.
  logic                d_valid;
  logic                d_inmap;
  logic                d_outmap;
  logic [1:0]          d_k;
  logic [2:0]          d_phase;
  logic                last_issue;

  assign op     = s_tdata[0];
  assign in_map = s_tdata[8:1];
  assign in_row = s_tdata[14:9];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  aesm4_map_mem u_mem (
    .clk     (clk),
    .wr_en   (accept && op == aesm4_pkg::OpLoad &&
              in_map < 8'(aesm4_pkg::MapCount) && in_row < 6'(aesm4_pkg::MapWords)),
    .wr_map  (in_map),
    .wr_row  (in_row),
    .wr_data (s_tdata[46:15]),
    .rd      (rd),
    .rd_data (rd_data)
  );

  // Issue sequence: 4 input maps, then per round j0,j1,j2,C,D, then 4 output maps.
  assign issuing = (state == ST_RUN);
  always_comb begin
    rd.valid = issuing;
    if (in_outer) begin
      rd.map = 8'(aesm4_pkg::MapIn) + 8'(k);
    end else if (out_stage) begin
      rd.map = 8'(aesm4_pkg::MapOut) + 8'(2'd3 - k);
    end else begin
      case (phase)
        3'd0, 3'd1, 3'd2: rd.map = 8'(aesm4_pkg::MapRound) + 8'(3 * int'(rnd)) + 8'(phase);
        3'd3:             rd.map = 8'(aesm4_pkg::MapC) + 8'(rnd);
        default:          rd.map = 8'(aesm4_pkg::MapD) + 8'(rnd);
      endcase
    end
  end
  assign last_issue = out_stage && k == 2'd3;

  // Operand of the map whose data arrives this cycle.
  always_comb begin
    if (d_inmap || d_outmap) begin
      ax = w[d_k];
    end else begin
      case (d_phase)
        3'd0:    ax = w[1];
        3'd1:    ax = w[2];
        3'd2:    ax = w[3];
        3'd3:    ax = w[0];
        default: ax = acc;
      endcase
    end
  end

  aesm4_affine u_aff (.map_word(rd_data), .x(ax), .y(ay));

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      sb[b*8 +: 8] = aesm4_pkg::sbox(acc[b*8 +: 8]);
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      d_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      d_valid <= issuing;
      case (state)
        ST_IDLE: begin
          if (accept && op == aesm4_pkg::OpEncrypt) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_issue) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          state    <= ST_OUT;
          m_tvalid <= 1'b1;
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Step counters for the issue side.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_outer  <= 1'b1;
      out_stage <= 1'b0;
      k         <= 2'd0;
      phase     <= 3'd0;
      rnd       <= '0;
    end else if (issuing) begin
      if (in_outer || out_stage) begin
        k <= k + 2'd1;
        if (in_outer && k == 2'd3) begin
          in_outer <= 1'b0;
        end
      end else if (phase == 3'd4) begin
        phase <= 3'd0;
        if (rnd == RndW'(ROUNDS - 1)) begin
          out_stage <= 1'b1;
        end else begin
          rnd <= rnd + RndW'(1);
        end
      end else begin
        phase <= phase + 3'd1;
      end
    end
    d_inmap  <= in_outer;
    d_outmap <= out_stage;
    d_k      <= k;
    d_phase  <= phase;
  end

  // Datapath: words, round accumulator and result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      w[0] <= s_tdata[110:79];
      w[1] <= s_tdata[78:47];
      w[2] <= s_tdata[174:143];
      w[3] <= s_tdata[142:111];
    end else if (d_valid) begin
      if (d_inmap || d_outmap) begin
        w[d_k] <= ay;
      end else begin
        case (d_phase)
          3'd0:       acc <= ay;
          3'd1, 3'd2: acc <= acc ^ ay;
          // The C output waits in w[0] while acc takes the S-box of the sum.
          3'd3: begin
            acc  <= sb;
            w[0] <= ay;
          end
          default: begin
            w[0] <= w[1];
            w[1] <= w[2];
            w[2] <= w[3];
            w[3] <= ay ^ w[0];
          end
        endcase
      end
    end
    // The last output map lands in this cycle, so word 3 comes straight from it.
    if (state == ST_DONE) begin
      m_tdata <= {w[1], w[0], ay, w[2]};
    end
  end

endmodule

@@ hw/rtl/aesm4_checker.sv @@
// Port-level checker for the affine-encoded SM4 core, bound to the top level.
module aesm4_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [175:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  // A pending result holds its value until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // No new request is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request taken while result pending");

  // An encrypt request makes the core busy on the next cycle.
  a_enc: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[0] |=> !s_tready)
    else $error("encrypt did not start");

  // A load request leaves the core ready.
  a_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tdata[0] |=> s_tready && !m_tvalid)
    else $error("load produced activity");

endmodule

bind affine_encoded_sm4_encrypt_core aesm4_checker u_chk (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the affine-encoded SM4 encryption core.
`timescale 1ns / 100ps

module tb_top;

  localparam int Rounds   = 32;
  localparam int Depth    = aesm4_pkg::MapCount * aesm4_pkg::MapWords;
  localparam int CycleMax = 2000000;
  localparam int DrainCyc = 400;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [175:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;

  // Expected ciphertexts, oldest first.
  logic [127:0] cipher_q[$];
  // Predictor copy of the map store.
  logic [31:0]  map_mem[Depth];
  bit           failed;
  int unsigned  cycle_cnt;
  bit           hold_off;

  affine_encoded_sm4_encrypt_core #(.ROUNDS(Rounds)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Apply one affine map from the predictor store.
  function automatic logic [31:0] map_apply(input int m, input logic [31:0] x);
    logic [31:0] y;
    y = '0;
    for (int r = 0; r < 32; r++) y[31-r] = ^(map_mem[m*aesm4_pkg::MapWords+r] & x);
    return y ^ map_mem[m*aesm4_pkg::MapWords+32];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] v);
    logic [31:0] o;
    for (int b = 0; b < 4; b++) o[8*b +: 8] = aesm4_pkg::sbox(v[8*b +: 8]);
    return o;
  endfunction

  // Full encryption through the stored maps.
  function automatic logic [127:0] cipher_of(input logic [63:0] hi, input logic [63:0] lo);
    logic [31:0] w[4];
    logic [31:0] t;
    w[0] = hi[63:32]; w[1] = hi[31:0]; w[2] = lo[63:32]; w[3] = lo[31:0];
    for (int k = 0; k < 4; k++) w[k] = map_apply(aesm4_pkg::MapIn + k, w[k]);
    for (int r = 0; r < Rounds; r++) begin
      t = map_apply(aesm4_pkg::MapRound + 3*r, w[1])
        ^ map_apply(aesm4_pkg::MapRound + 3*r + 1, w[2])
        ^ map_apply(aesm4_pkg::MapRound + 3*r + 2, w[3]);
      t = sub_word(t);
      t = map_apply(aesm4_pkg::MapC + r, w[0]) ^ map_apply(aesm4_pkg::MapD + r, t);
      w[0] = w[1]; w[1] = w[2]; w[2] = w[3]; w[3] = t;
    end
    for (int k = 0; k < 4; k++) w[k] = map_apply(aesm4_pkg::MapOut + 3 - k, w[k]);
    // m_tdata: result_hi low, result_lo high.
    return {w[1], w[0], w[3], w[2]};
  endfunction

  // Send one request and update the prediction when it is accepted.
  task automatic send_req(input logic op, input logic [7:0] mi, input logic [5:0] ri,
                          input logic [31:0] tw, input logic [63:0] hi, input logic [63:0] lo);
    s_tdata  <= {1'b0, lo, hi, tw, ri, mi, op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == aesm4_pkg::OpLoad) begin
      if (mi < aesm4_pkg::MapCount && ri < aesm4_pkg::MapWords) begin
        map_mem[mi*aesm4_pkg::MapWords+ri] = tw;
      end
    end else begin
      cipher_q.push_back(cipher_of(hi, lo));
    end
  endtask

  task automatic idle_sender(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic load_word(input int m, input int r, input logic [31:0] v);
    send_req(aesm4_pkg::OpLoad, m[7:0], r[5:0], v, {$urandom, $urandom},
             {$urandom, $urandom});
  endtask

  task automatic encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
    send_req(aesm4_pkg::OpEncrypt, 8'($urandom), 6'($urandom), $urandom, hi, lo);
  endtask

  // Random send with occasional bursts and gaps.
  task automatic gap_maybe();
    if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 6));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
  endtask

  // Fill every map: zero, unit-matrix or random rows; mode 2 bursty.
  task automatic test_load_all(input int mode);
    logic [31:0] v;
    for (int m = 0; m < aesm4_pkg::MapCount; m++)
      for (int r = 0; r < aesm4_pkg::MapWords; r++) begin
        case (mode)
          0: v = 32'h0;
          1: v = (r < 32) ? (32'h8000_0000 >> r) : 32'hffff_ffff;
          default: v = $urandom;
        endcase
        load_word(m, r, v);
        if (mode == 2) gap_maybe();
      end
  endtask

  // Directed: field extremes, loads out of range, encrypt under fixed maps.
  task automatic test_directed();
    encrypt_block('0, '0);
    encrypt_block('1, '1);
    encrypt_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    load_word(200, 0, 32'hdead_beef);
    load_word(255, 63, 32'hffff_ffff);
    load_word(0, 33, 32'h1234_5678);
    load_word(0, 63, 32'h0);
    encrypt_block(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000);
    wait_drained();
  endtask

  // Random mix: half encrypts, some table rewrites, some ignored loads.
  task automatic test_random(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 5)
        encrypt_block({$urandom, $urandom}, {$urandom, $urandom});
      else if (k < 9)
        load_word($urandom_range(0, aesm4_pkg::MapCount-1),
                  $urandom_range(0, aesm4_pkg::MapWords-1), $urandom);
      else
        load_word($urandom_range(aesm4_pkg::MapCount, 255), $urandom_range(0, 63), $urandom);
      gap_maybe();
    end
  endtask

  // Receiver stalls long while the sender keeps offering encrypts.
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) encrypt_block({$urandom, $urandom}, {$urandom, $urandom});
    wait_drained();
  endtask

  // Receiver: its own stall pattern, plus a long counted hold-off.
  initial begin
    int hold_cnt;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_cnt = 0;
        m_tready <= 1'b0;
        while (hold_cnt < 1500) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_off = 1'b0;
      end
      case (cycle_cnt[11:10])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= ($urandom_range(0, 1) == 1);
        2'd2: m_tready <= ($urandom_range(0, 7) == 0);
        default: m_tready <= (cycle_cnt[3:0] < 12);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    logic [127:0] exp_d;
    if (!rst && m_tvalid && m_tready) begin
      if (cipher_q.size() == 0) begin
        $error("result with no expectation: %h", m_tdata);
        failed = 1'b1;
      end else begin
        exp_d = cipher_q.pop_front();
        if (m_tdata[63:0] !== exp_d[63:0]) begin
          $error("result_hi expected %h actual %h", exp_d[63:0], m_tdata[63:0]);
          failed = 1'b1;
        end
        if (m_tdata[127:64] !== exp_d[127:64]) begin
          $error("result_lo expected %h actual %h", exp_d[127:64], m_tdata[127:64]);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleMax) begin
      $display("affine_encoded_sm4_encrypt_core: mismatch");
      $finish;
    end
  end

  initial begin
    failed    = 1'b0;
    cycle_cnt = 0;
    hold_off  = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_all(2);
    test_directed();
    test_backpressure();
    test_random(300);
    wait_drained();
    repeat (DrainCyc) @(posedge clk);
    if (!failed && cipher_q.size() == 0) begin
      $display("affine_encoded_sm4_encrypt_core: match");
    end else begin
      $display("affine_encoded_sm4_encrypt_core: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/aesm4_pkg.sv
hw/rtl/aesm4_map_mem.sv
hw/rtl/aesm4_affine.sv
hw/rtl/affine_encoded_sm4_encrypt_core.sv
hw/rtl/aesm4_checker.sv
verif/tb_top.sv
